@@ design/lion_optimizer_update_macros.svh @@
// Assertion shorthands for the checker file of this block.
`ifndef LION_OPTIMIZER_UPDATE_MACROS_SVH
`define LION_OPTIMIZER_UPDATE_MACROS_SVH

// Concurrent assertion on a given clock and active-low reset.
`define LION_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent assertion on the block clock and reset.
`define LION_ASSERT(label, prop, msg) \
  `LION_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

@@ design/lion_pkg.sv @@
package lion_pkg;

  // Field widths of the stream items and the coefficient registers.
  localparam int unsigned IdxW  = 12;
  localparam int unsigned DataW = 32;
  localparam int unsigned CoefW = 16;

  // Packed stream widths, padded to whole bytes.
  localparam int unsigned SInW  = ((IdxW + 2 * DataW + 7) / 8) * 8;
  localparam int unsigned MOutW = ((DataW + IdxW + 7) / 8) * 8;

  // Configuration port.
  localparam int unsigned AddrW = 5;
  localparam int unsigned ApbW  = 32;
  localparam int unsigned SelW  = AddrW - 2;

  // Register indexes.
  localparam logic [SelW-1:0] RegLearnRate = 3'd0;
  localparam logic [SelW-1:0] RegBetaInterp = 3'd1;
  localparam logic [SelW-1:0] RegBetaMom   = 3'd2;
  localparam logic [SelW-1:0] RegDecay     = 3'd3;
  localparam logic [SelW-1:0] RegMaximize  = 3'd4;

  // Register reset values.
  localparam logic [CoefW-1:0] LearnRateRst  = 16'd7;
  localparam logic [CoefW-1:0] BetaInterpRst = 16'd58982;
  localparam logic [CoefW-1:0] BetaMomRst    = 16'd64881;
  localparam logic [CoefW-1:0] DecayRst      = 16'd0;

  // One in Q0.16, which needs one bit above the coefficient width.
  localparam logic [CoefW:0] OneQ16 = {1'b1, {CoefW{1'b0}}};

  // Datapath widths.
  localparam int unsigned ProdMW = CoefW + 1 + DataW;      // coef * momentum
  localparam int unsigned ProdGW = CoefW + 2 + DataW + 1;  // (1 - coef) * gradient
  localparam int unsigned SumW   = ProdGW + 1;
  localparam int unsigned RndW   = SumW - CoefW;
  localparam int unsigned MomW   = RndW + 1;
  localparam int unsigned NwW    = DataW + 3;
  localparam int unsigned ScaleW = 2 * CoefW;
  localparam int unsigned DecW   = ScaleW + DataW;

  localparam logic [DataW-1:0] ValMax = {1'b0, {(DataW - 1){1'b1}}};
  localparam logic [DataW-1:0] ValMin = {1'b1, {(DataW - 1){1'b0}}};

  typedef struct packed {
    logic [CoefW-1:0] learning_rate;
    logic [CoefW-1:0] beta_interp;
    logic [CoefW-1:0] beta_momentum;
    logic [CoefW-1:0] weight_decay;
    logic             maximize;
  } lion_cfg_t;

endpackage

@@ design/lion_regs.sv @@
module lion_regs
  import lion_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [ApbW-1:0]  pwdata,
  output logic [ApbW-1:0]  prdata,
  output logic             pready,
  output lion_cfg_t        cfg_o
);

  lion_cfg_t       cfg_q, cfg_d;
  logic [SelW-1:0] reg_sel;
  logic            wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[AddrW-1:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        RegLearnRate:  cfg_d.learning_rate = pwdata[CoefW-1:0];
        RegBetaInterp: cfg_d.beta_interp   = pwdata[CoefW-1:0];
        RegBetaMom:    cfg_d.beta_momentum = pwdata[CoefW-1:0];
        RegDecay:      cfg_d.weight_decay  = pwdata[CoefW-1:0];
        RegMaximize:   cfg_d.maximize      = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegLearnRate:  prdata = ApbW'(cfg_q.learning_rate);
      RegBetaInterp: prdata = ApbW'(cfg_q.beta_interp);
      RegBetaMom:    prdata = ApbW'(cfg_q.beta_momentum);
      RegDecay:      prdata = ApbW'(cfg_q.weight_decay);
      RegMaximize:   prdata = ApbW'(cfg_q.maximize);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.learning_rate <= LearnRateRst;
      cfg_q.beta_interp   <= BetaInterpRst;
      cfg_q.beta_momentum <= BetaMomRst;
      cfg_q.weight_decay  <= DecayRst;
      cfg_q.maximize      <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/lion_optimizer_update.sv @@
// Lion optimizer update, one parameter element per item. Each input transfer carries an
// element index, its gradient and its weight (signed Q16.16); the block reads that
// element's momentum from an internal memory of MOMENTUM_ENTRIES words
// (the index wraps modulo the depth), returns the new weight
// w - lr*sign(c) - round(lr*decay*w) saturated to 32 bits, and writes back the rounded,
// saturated new momentum. After reset the block zeroes the momentum memory word by word
// and holds s_axis_tready low meanwhile; the APB registers can be written during that
// time. Items are processed one at a time by a sequencer around the memory's
// read-modify-write, in the steps index wrap, memory read, multiply, sum, round and
// write back, and output load; the output load waits while the output side stalls with
// the previous result still held, and only then can the block take the next item. A new
// item is accepted while an earlier result is held in the output register. Registers
// should be changed only while no item is in flight.
module lion_optimizer_update
  import lion_pkg::*;
#(
  parameter int unsigned MOMENTUM_ENTRIES = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [SInW-1:0]  s_axis_tdata,   // element_index, gradient, weight, zero pad
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [MOutW-1:0] m_axis_tdata,   // new_weight, result_index, zero pad
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [ApbW-1:0]  pwdata,
  output logic [ApbW-1:0]  prdata,
  output logic             pready
);

  localparam int unsigned SlotW = (MOMENTUM_ENTRIES > 1) ? $clog2(MOMENTUM_ENTRIES) : 1;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(MOMENTUM_ENTRIES - 1);

  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StQuot  = 4'd2;
  localparam logic [3:0] StSlot  = 4'd3;
  localparam logic [3:0] StRead  = 4'd4;
  localparam logic [3:0] StMul   = 4'd5;
  localparam logic [3:0] StSum   = 4'd6;
  localparam logic [3:0] StFin   = 4'd7;
  localparam logic [3:0] StOut   = 4'd8;

  lion_cfg_t cfg;

  lion_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // Control state.
  logic [3:0]       state_q, state_d;
  logic [SlotW-1:0] clr_q, clr_d;
  logic             out_valid_q, out_valid_d;

  // Item payload.
  logic [IdxW-1:0]          idx_q;
  logic signed [DataW:0]    g_q;
  logic [DataW-1:0]         w_q;
  logic [ScaleW-1:0]        scale_q;
  logic [SlotW-1:0]         slot_q, slot_d;
  logic signed [ProdMW-1:0] p_dm_q, p_mm_q, p_dm_d, p_mm_d;
  logic signed [ProdGW-1:0] p_dg_q, p_mg_q, p_dg_d, p_mg_d;
  logic [DecW-1:0]          dprod_q, dprod_d;
  logic                     dir_pos_q, dir_neg_q;
  logic signed [SumW-1:0]   dir_d, mom_q, mom_d;
  logic [DataW-1:0]         dmag_q, dmag_d;
  logic [DataW-1:0]         nw_q, nw_d;
  logic [DataW-1:0]         out_nw_q;
  logic [IdxW-1:0]          out_idx_q;

  // Momentum memory.
  logic [DataW-1:0] mem_q [MOMENTUM_ENTRIES];
  logic [DataW-1:0] mem_rdata_q;
  logic             mem_we;
  logic [SlotW-1:0] mem_waddr;
  logic [DataW-1:0] mem_wdata;

  // Input fields.
  logic [IdxW-1:0]       s_idx;
  logic [DataW-1:0]      s_grad, s_wgt;
  logic signed [DataW:0] g_ext, g_in;
  logic                  in_acc, out_load;

  assign s_idx  = s_axis_tdata[IdxW-1:0];
  assign s_grad = s_axis_tdata[IdxW +: DataW];
  assign s_wgt  = s_axis_tdata[IdxW + DataW +: DataW];

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_load      = (state_q == StOut) && (!out_valid_q || m_axis_tready);

  assign g_ext = $signed({s_grad[DataW-1], s_grad});
  assign g_in  = cfg.maximize ? -g_ext : g_ext;

  // Index wrap: the slot is the index modulo the depth, found with a reciprocal
  // multiply that is exact for every index value.
  if (MOMENTUM_ENTRIES < (1 << IdxW)) begin : g_wrap
    localparam int unsigned RecShift = IdxW + $clog2(MOMENTUM_ENTRIES);
    localparam int unsigned RecVal =
      ((1 << RecShift) + MOMENTUM_ENTRIES - 1) / MOMENTUM_ENTRIES;
    localparam int unsigned RecW = IdxW + 2;
    localparam logic [RecW-1:0] Recip   = RecW'(RecVal);
    localparam logic [IdxW-1:0] Entries = IdxW'(MOMENTUM_ENTRIES);

    logic [IdxW+RecW-1:0] qprod;
    logic [2*IdxW-1:0]    back;
    logic [IdxW-1:0]      quot_q;

    assign qprod = idx_q * Recip;
    assign back  = quot_q * Entries;
    assign slot_d = SlotW'(idx_q - back[IdxW-1:0]);

    always_ff @(posedge clk_i) begin
      if (state_q == StQuot) begin
        quot_q <= IdxW'(qprod >> RecShift);
      end
    end
  end else begin : g_nowrap
    assign slot_d = SlotW'(idx_q);
  end

  // Products of the coefficients with the momentum read out of the memory, the gradient and the weight magnitude.
  logic [CoefW:0]   one_bi, one_bm;
  logic [DataW-1:0] wmag;

  assign one_bi = OneQ16 - {1'b0, cfg.beta_interp};
  assign one_bm = OneQ16 - {1'b0, cfg.beta_momentum};
  assign wmag   = w_q[DataW-1] ? DataW'(-w_q) : w_q;

  assign p_dm_d  = $signed({1'b0, cfg.beta_interp}) * $signed(mem_rdata_q);
  assign p_mm_d  = $signed({1'b0, cfg.beta_momentum}) * $signed(mem_rdata_q);
  assign p_dg_d  = $signed({1'b0, one_bi}) * g_q;
  assign p_mg_d  = $signed({1'b0, one_bm}) * g_q;
  assign dprod_d = scale_q * wmag;

  // Sums and the rounded decay magnitude.
  assign dir_d  = SumW'(p_dm_q) + SumW'(p_dg_q);
  assign mom_d  = SumW'(p_mm_q) + SumW'(p_mg_q);
  assign dmag_d = DataW'((dprod_q + (DecW'(1) << (DataW - 1))) >> DataW);

  // New momentum: round half away from zero, then saturate.
  logic                   mom_neg;
  logic [SumW-1:0]        mom_mag;
  logic [RndW-1:0]        mom_rnd;
  logic signed [MomW-1:0] mom_sgn;
  logic [MomW-DataW:0]    mom_top;
  logic [DataW-1:0]       mom_sat;

  assign mom_neg = mom_q[SumW-1];
  assign mom_mag = mom_neg ? SumW'(-mom_q) : SumW'(mom_q);
  assign mom_rnd = RndW'((mom_mag + (SumW'(1) << (CoefW - 1))) >> CoefW);
  assign mom_sgn = mom_neg ? -$signed({1'b0, mom_rnd}) : $signed({1'b0, mom_rnd});
  assign mom_top = mom_sgn[MomW-1:DataW-1];

  always_comb begin
    if ((&mom_top) || !(|mom_top)) begin
      mom_sat = mom_sgn[DataW-1:0];
    end else if (mom_sgn[MomW-1]) begin
      mom_sat = ValMin;
    end else begin
      mom_sat = ValMax;
    end
  end

  // New weight.
  logic [NwW-1:0]      step_term, decay_term, nw_wide, lr_ext, dmag_ext;
  logic [NwW-DataW:0]  nw_top;

  assign lr_ext   = NwW'(cfg.learning_rate);
  assign dmag_ext = NwW'(dmag_q);

  always_comb begin
    if (dir_pos_q) begin
      step_term = lr_ext;
    end else if (dir_neg_q) begin
      step_term = -lr_ext;
    end else begin
      step_term = '0;
    end
  end

  assign decay_term = w_q[DataW-1] ? -dmag_ext : dmag_ext;
  assign nw_wide    = {{(NwW - DataW){w_q[DataW-1]}}, w_q} - step_term - decay_term;
  assign nw_top     = nw_wide[NwW-1:DataW-1];

  always_comb begin
    if ((&nw_top) || !(|nw_top)) begin
      nw_d = nw_wide[DataW-1:0];
    end else if (nw_wide[NwW-1]) begin
      nw_d = ValMin;
    end else begin
      nw_d = ValMax;
    end
  end

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    mem_we    = 1'b0;
    mem_waddr = slot_q;
    mem_wdata = mom_sat;
    unique case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == LastSlot) begin
          state_d = StIdle;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      StIdle: begin
        if (in_acc) begin
          state_d = StQuot;
        end
      end
      StQuot: state_d = StSlot;
      StSlot: state_d = StRead;
      StRead: state_d = StMul;
      StMul:  state_d = StSum;
      StSum:  state_d = StFin;
      StFin: begin
        mem_we  = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      idx_q   <= s_idx;
      g_q     <= g_in;
      w_q     <= s_wgt;
      scale_q <= cfg.learning_rate * cfg.weight_decay;
    end
    if (state_q == StSlot) begin
      slot_q <= slot_d;
    end
    if (state_q == StMul) begin
      p_dm_q  <= p_dm_d;
      p_dg_q  <= p_dg_d;
      p_mm_q  <= p_mm_d;
      p_mg_q  <= p_mg_d;
      dprod_q <= dprod_d;
    end
    if (state_q == StSum) begin
      dir_pos_q <= !dir_d[SumW-1] && (dir_d != '0);
      dir_neg_q <= dir_d[SumW-1];
      mom_q     <= mom_d;
      dmag_q    <= dmag_d;
    end
    if (state_q == StFin) begin
      nw_q <= nw_d;
    end
    if (out_load) begin
      out_nw_q  <= nw_q;
      out_idx_q <= idx_q;
    end
  end

  // An item's write-back lands before the next item's slot is read, and the
  // read data is used only in the multiply state, so no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[slot_q];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(MOutW - DataW - IdxW){1'b0}}, out_idx_q, out_nw_q};

endmodule

@@ design/lion_chk.sv @@
`include "lion_optimizer_update_macros.svh"

module lion_chk
  import lion_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [SInW-1:0]  s_axis_tdata,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [MOutW-1:0] m_axis_tdata,
  input logic             pready
);

  logic [1:0]      outstanding_q;
  logic [IdxW-1:0] last_idx_q;
  logic            in_xfer, out_xfer;

  assign in_xfer  = s_axis_tvalid & s_axis_tready;
  assign out_xfer = m_axis_tvalid & m_axis_tready;

  // Items taken in whose result has not been handed out yet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else begin
      outstanding_q <= outstanding_q + 2'(in_xfer) - 2'(out_xfer);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      last_idx_q <= s_axis_tdata[IdxW-1:0];
    end
  end

  `LION_ASSERT(a_pready_high, pready, "pready dropped")
  `LION_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `LION_ASSERT(a_no_phantom, m_axis_tvalid |-> outstanding_q != 2'd0, "result without an item")
  `LION_ASSERT(a_in_flight, outstanding_q != 2'd3, "more than two items in flight")
  `LION_ASSERT(a_idx_echo, m_axis_tvalid && outstanding_q == 2'd1 |-> m_axis_tdata[DataW +: IdxW] == last_idx_q, "result index does not match")

endmodule

bind lion_optimizer_update lion_chk u_lion_chk (.*);
